### src/bsd_pkg.sv
// ----------------------------------------------------------------------------
// Button sequence detector package
// Shared widths, item codes and the structs that pass between the modules.
// ----------------------------------------------------------------------------
package bsd_pkg;

  localparam int unsigned PadW   = 32;
  localparam int unsigned StepW  = 4;
  localparam int unsigned WaitW  = 8;
  localparam int unsigned RowIdW = 3;
  localparam int unsigned SlotIdW = 2;

  // Packed widths of the stream payloads, rounded up to whole bytes.
  localparam int unsigned InFieldsW = PadW + RowIdW + SlotIdW + PadW + 1;
  localparam int unsigned InDataW   = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = 1 + StepW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  localparam logic [WaitW-1:0] WaitLimitReset = WaitW'(30);

  // Item kinds carried on the input tuser bit.
  localparam logic FuncFrame = 1'b0;
  localparam logic FuncLoad  = 1'b1;

  typedef struct packed {
    logic               func;
    logic [PadW-1:0]    pad_state;
    logic [RowIdW-1:0]  step_index;
    logic [SlotIdW-1:0] slot_index;
    logic [PadW-1:0]    entry_mask;
    logic               entry_valid;
  } in_item_t;

  typedef struct packed {
    logic             sequence_done;
    logic [StepW-1:0] current_step;
  } result_t;

  // Slot write toward the step table.
  typedef struct packed {
    logic               en;
    logic [RowIdW-1:0]  row;
    logic [SlotIdW-1:0] slot;
    logic [PadW-1:0]    mask;
    logic               used;
  } tbl_wr_t;

  // Sequencer state seen by the top level.
  typedef struct packed {
    logic [StepW-1:0] step;
    logic [WaitW-1:0] wait_count;
  } status_t;

endpackage

### src/bsd_step_table.sv
// ----------------------------------------------------------------------------
// Button sequence step table
// Rows of button-mask slots with per-slot valid bits, one write port and a
// read of the current row plus an emptiness check of the following row.
// ----------------------------------------------------------------------------
module bsd_step_table
  import bsd_pkg::*;
#(
  parameter int unsigned STEPS  = 8,
  parameter int unsigned COMBOS = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tbl_wr_t                    wr_i,
  input  logic [StepW-1:0]           step_i,
  input  logic [StepW-1:0]           next_step_i,
  output logic [COMBOS-1:0][PadW-1:0] row_mask_o,
  output logic [COMBOS-1:0]          row_used_o,
  output logic                       row_valid_o,
  output logic                       next_empty_o
);

  logic [STEPS-1:0][COMBOS-1:0][PadW-1:0] mask_q;
  logic [STEPS-1:0][COMBOS-1:0]           used_q;

  // Writes outside the table simply match no row or slot and are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (wr_i.en) begin
      for (int r = 0; r < STEPS; r++) begin
        for (int c = 0; c < COMBOS; c++) begin
          if (StepW'(wr_i.row) == StepW'(r) && 4'(wr_i.slot) == 4'(c)) begin
            used_q[r][c] <= wr_i.used;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      for (int r = 0; r < STEPS; r++) begin
        for (int c = 0; c < COMBOS; c++) begin
          if (StepW'(wr_i.row) == StepW'(r) && 4'(wr_i.slot) == 4'(c)) begin
            mask_q[r][c] <= wr_i.mask;
          end
        end
      end
    end
  end

  // Row selection; a step past the last row reads as no row at all.
  always_comb begin
    row_mask_o   = '0;
    row_used_o   = '0;
    row_valid_o  = 1'b0;
    next_empty_o = 1'b1;
    for (int r = 0; r < STEPS; r++) begin
      if (step_i == StepW'(r)) begin
        row_mask_o  = mask_q[r];
        row_used_o  = used_q[r];
        row_valid_o = 1'b1;
      end
      if (next_step_i == StepW'(r)) begin
        next_empty_o = !used_q[r][0];
      end
    end
  end

endmodule

### src/bsd_core.sv
// ----------------------------------------------------------------------------
// Button sequence core
// Step position, wait counter and previous button state, updated once per
// processed item from the selected table row.
// ----------------------------------------------------------------------------
module bsd_core
  import bsd_pkg::*;
#(
  parameter int unsigned COMBOS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wait_limit_we_i,
  input  logic [WaitW-1:0]            wait_limit_i,
  input  logic                        fire_i,
  input  in_item_t                    item_i,
  input  logic [COMBOS-1:0][PadW-1:0] row_mask_i,
  input  logic [COMBOS-1:0]           row_used_i,
  input  logic                        row_valid_i,
  input  logic                        next_empty_i,
  output logic [StepW-1:0]            step_o,
  output logic [StepW-1:0]            next_step_o,
  output tbl_wr_t                     wr_o,
  output result_t                     res_o,
  output status_t                     status_o
);

  logic [StepW-1:0] step_q, step_d;
  logic [WaitW-1:0] wait_q, wait_d;
  logic [PadW-1:0]  prev_q, prev_d;
  logic [WaitW-1:0] limit_q;

  logic [COMBOS-1:0] hit;
  logic              match;
  logic              scanning;
  logic [WaitW:0]    wait_inc;
  logic              done;

  always_comb begin
    for (int k = 0; k < COMBOS; k++) begin
      hit[k] = ((item_i.pad_state & row_mask_i[k]) != '0) &&
               ((prev_q & row_mask_i[k]) == '0);
    end
  end

  // Slots are checked in order up to the first unused one.
  always_comb begin
    match    = 1'b1;
    scanning = 1'b1;
    for (int k = 0; k < COMBOS; k++) begin
      if (scanning) begin
        if (!row_used_i[k]) begin
          scanning = 1'b0;
        end else if (!hit[k]) begin
          match = 1'b0;
        end
      end
    end
    if (!row_valid_i) begin
      match = 1'b1;
    end
  end

  assign next_step_o = step_q + StepW'(1);
  assign wait_inc    = {1'b0, wait_q} + (WaitW+1)'(1);

  always_comb begin
    step_d = step_q;
    wait_d = wait_q;
    prev_d = prev_q;
    done   = 1'b0;
    if (item_i.func == FuncFrame) begin
      prev_d = item_i.pad_state;
      if (match) begin
        wait_d = '0;
        if (next_empty_i) begin
          step_d = '0;
          done   = 1'b1;
        end else begin
          step_d = next_step_o;
        end
      end else if (wait_inc >= {1'b0, limit_q}) begin
        wait_d = '0;
        step_d = '0;
      end else begin
        wait_d = wait_inc[WaitW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      wait_q  <= '0;
      prev_q  <= '0;
      limit_q <= WaitLimitReset;
    end else begin
      if (fire_i) begin
        step_q <= step_d;
        wait_q <= wait_d;
        prev_q <= prev_d;
      end
      if (wait_limit_we_i) begin
        limit_q <= wait_limit_i;
      end
    end
  end

  assign step_o = step_q;

  assign wr_o.en   = fire_i && (item_i.func == FuncLoad);
  assign wr_o.row  = item_i.step_index;
  assign wr_o.slot = item_i.slot_index;
  assign wr_o.mask = item_i.entry_mask;
  assign wr_o.used = item_i.entry_valid;

  assign res_o.sequence_done = done;
  assign res_o.current_step  = step_d;

  assign status_o.step       = step_q;
  assign status_o.wait_count = wait_q;

endmodule

### src/button_sequence_detector_top.sv
// ----------------------------------------------------------------------------
// Button sequence detector, top level
// Tracks a programmable sequence of button combinations with a timeout.
// ----------------------------------------------------------------------------
// The input stream carries two kinds of item, told apart by s_axis_tuser:
// a frame item with the current 32-bit button bitmap, and a load item that
// writes one slot (mask and valid bit) of the step table. Every item gives
// exactly one result transfer on the output stream: a done flag, set when
// the frame completed the whole sequence, and the step reached afterwards.
// The wait limit is a single register written through wait_limit_we_i and
// wait_limit_i; write it only while no item is in flight.
//
// Each accepted item lands in an input register; once the output register
// is free, the row match, step update and table write are done in one pass
// and the result is captured in the output register, from which it leaves
// on the output stream. With the receiver ready, one item is accepted every
// cycle.
// The output register lets the next item enter while a result waits; when
// the receiver holds m_axis_tready low, both registers fill and the input
// side then stalls until the result is taken. Reset clears all table valid
// bits, the step, the wait counter and the previous button state, and sets
// the wait limit to 30 frames.
// ----------------------------------------------------------------------------
module button_sequence_detector_top
  import bsd_pkg::*;
#(
  parameter int unsigned STEPS  = 8,
  parameter int unsigned COMBOS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wait_limit_we_i,
  input  logic [WaitW-1:0]    wait_limit_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [31:0] pad_state, [34:32] step_index, [36:35] slot_index,
  // [68:37] entry_mask, [69] entry_valid, upper bits zero.
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] func: 0 frame item, 1 load item.
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] sequence_done, [4:1] current_step, upper bits zero.
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic     in_valid_q;
  in_item_t in_item_q, in_item_d;
  logic     out_valid_q;
  result_t  out_res_q;

  logic     fire;
  logic     out_free;

  tbl_wr_t                     tbl_wr;
  logic [StepW-1:0]            cur_step;
  logic [StepW-1:0]            next_step;
  logic [COMBOS-1:0][PadW-1:0] row_mask;
  logic [COMBOS-1:0]           row_used;
  logic                        row_valid;
  logic                        next_empty;
  result_t                     res;
  status_t                     status;

  // The item in the input register is processed whenever the output
  // register is empty or is being emptied in this cycle.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  // Unpack the input transfer into its fields.
  assign in_item_d.func        = s_axis_tuser;
  assign in_item_d.pad_state   = s_axis_tdata[PadW-1:0];
  assign in_item_d.step_index  = s_axis_tdata[PadW +: RowIdW];
  assign in_item_d.slot_index  = s_axis_tdata[PadW+RowIdW +: SlotIdW];
  assign in_item_d.entry_mask  = s_axis_tdata[PadW+RowIdW+SlotIdW +: PadW];
  assign in_item_d.entry_valid = s_axis_tdata[2*PadW+RowIdW+SlotIdW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= in_item_d;
    end
    if (fire) begin
      out_res_q <= res;
    end
  end

  bsd_step_table #(
    .STEPS  (STEPS),
    .COMBOS (COMBOS)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (tbl_wr),
    .step_i       (cur_step),
    .next_step_i  (next_step),
    .row_mask_o   (row_mask),
    .row_used_o   (row_used),
    .row_valid_o  (row_valid),
    .next_empty_o (next_empty)
  );

  bsd_core #(
    .COMBOS (COMBOS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wait_limit_we_i (wait_limit_we_i),
    .wait_limit_i    (wait_limit_i),
    .fire_i          (fire),
    .item_i          (in_item_q),
    .row_mask_i      (row_mask),
    .row_used_i      (row_used),
    .row_valid_i     (row_valid),
    .next_empty_i    (next_empty),
    .step_o          (cur_step),
    .next_step_o     (next_step),
    .wr_o            (tbl_wr),
    .res_o           (res),
    .status_o        (status)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'({out_res_q.current_step, out_res_q.sequence_done});

  // A completed sequence always restarts at the first step.
  a_done_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[4:1] == '0))
    else $error("sequence_done reported with a nonzero step");

  // The step position never leaves the table.
  a_step_in_table : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(status.step) < STEPS)
    else $error("step position beyond the last table row");

  // A load item leaves the sequencer state untouched.
  a_load_keeps_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_item_q.func == FuncLoad) |=> $stable(status))
    else $error("load item changed the step or wait counter");

endmodule
